FILE: sv/tome_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tome_pkg
// Shared widths and constants for the (1-exp(-x))/x series evaluator.
// ----------------------------------------------------------------------------
package tome_pkg;

  localparam int X_W     = 51;  // signed argument
  localparam int SUM_W   = 52;  // unsigned result
  localparam int ACC_W   = 53;  // signed running sum
  localparam int TERMS_W = 7;
  localparam int TOL_W   = 17;

  // term magnitude, also the width of |x|
  localparam int MAG_W = 51;
  localparam logic [MAG_W-1:0] TERM_MAX = {MAG_W{1'b1}};

  // multiplier: term times one 17-bit slice of |x| per cycle
  localparam int CHUNK_W   = 17;
  localparam int MUL_STEPS = MAG_W / CHUNK_W;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int PART_W    = MAG_W + CHUNK_W;

  // divider: quotient digits per cycle over a fixed-width dividend
  localparam int DVD_W      = 60;
  localparam int DIG_BITS   = 4;
  localparam int DIV_CYCLES = DVD_W / DIG_BITS;
  localparam int DCNT_W     = $clog2(DIV_CYCLES);

  typedef logic [MAG_W-1:0] mag_t;
  typedef logic signed [ACC_W-1:0] acc_t;

endpackage

FILE: sv/taylor_one_minus_exp_over_x_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_one_minus_exp_over_x_core
// Fixed-point (1-exp(-x))/x by its Taylor series on one shared mul/div unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: in_x_value, signed Q3.48, taken when in_valid && !in_stall.
//   in_stall is high from acceptance until the result is handed to the
//   output register; one word is worked on at a time.
//   Result word: out_sum_value (saturated, Q4.48 unsigned), out_terms_used,
//   out_not_converged, offered on out_valid, taken when !out_stall.
//   The output register frees the input side: a new word can be worked on
//   while a finished result waits. A later result waits in its final state
//   until the output register is free.
//   Per term: add/check, 51x17 multiply-accumulate, scale, then radix-16
//   division by the term index; the division is the longest of these steps.
//   cfg_stop_tolerance is written on cfg_valid (cfg_ready is always high);
//   write it only while the block is idle.
//   Reset (rst_n low, synchronous) empties the output register, returns the
//   sequencer to idle and sets the tolerance to 1.
// ----------------------------------------------------------------------------
module taylor_one_minus_exp_over_x_core
  import tome_pkg::*;
#(
  parameter int MAX_TERMS = 64,
  parameter int FRAC_BITS = 48
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [X_W-1:0]      in_x_value,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [SUM_W-1:0]    out_sum_value,
  output logic [TERMS_W-1:0]  out_terms_used,
  output logic                out_not_converged,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TOL_W-1:0]    cfg_stop_tolerance
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_MUL    = 3'd2;
  localparam logic [2:0] ST_PREP   = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  localparam mag_t ONE_MAG = (FRAC_BITS >= MAG_W) ? TERM_MAX :
                             MAG_W'(64'd1 << FRAC_BITS);
  localparam logic [TERMS_W-1:0] MAX_CNT = TERMS_W'(MAX_TERMS);
  localparam acc_t SUM_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam acc_t SUM_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  logic [2:0]          state_r, state_nxt;
  logic [TOL_W-1:0]    tol_r, tol_nxt;
  mag_t                x_mag_r, x_mag_nxt;
  logic                x_pos_r, x_pos_nxt;
  mag_t                term_r, term_nxt;
  logic                neg_r, neg_nxt;
  acc_t                sum_r, sum_nxt;
  logic [TERMS_W-1:0]  cnt_r, cnt_nxt;
  logic [TERMS_W-1:0]  div_r, div_nxt;
  logic                nc_r, nc_nxt;
  logic [1:0]          mcnt_r, mcnt_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [DVD_W-1:0]    dvd_r, dvd_nxt;
  logic [TERMS_W-1:0]  rem_r, rem_nxt;

  logic                ov_r, ov_nxt;
  logic [SUM_W-1:0]    o_sum_r, o_sum_nxt;
  logic [TERMS_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic                o_nc_r, o_nc_nxt;

  // datapath helpers
  logic                in_acc;
  logic                out_free;
  logic                run;
  logic                tol_met;
  logic [ACC_W:0]      sum_ext;
  logic [ACC_W:0]      term_ext;
  logic [CHUNK_W-1:0]  x_chunk;
  logic [PART_W-1:0]   mul_part;
  logic [PROD_W-1:0]   p_full;
  logic                p_ovf;
  logic [DVD_W-1:0]    dv;
  logic [TERMS_W-1:0]  rm;
  logic [TERMS_W:0]    r8;
  logic                upd_en;
  mag_t                upd_mag;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !ov_r || !out_stall;
  assign tol_met  = term_r >= MAG_W'(tol_r);
  assign run      = tol_met && (cnt_r < MAX_CNT);

  // add of the signed term with a guard bit; ST_CHECK saturates the result
  always_comb begin
    term_ext = {{(ACC_W+1-MAG_W){1'b0}}, term_r};
    if (neg_r) begin
      term_ext = -term_ext;
    end
    sum_ext = {sum_r[ACC_W-1], sum_r} + term_ext;
  end

  always_comb begin
    case (mcnt_r)
      2'd2:    x_chunk = x_mag_r[3*CHUNK_W-1:2*CHUNK_W];
      2'd1:    x_chunk = x_mag_r[2*CHUNK_W-1:CHUNK_W];
      default: x_chunk = x_mag_r[CHUNK_W-1:0];
    endcase
  end

  assign mul_part = term_r * x_chunk;
  assign p_full   = prod_r >> FRAC_BITS;
  assign p_ovf    = |p_full[PROD_W-1:DVD_W];

  // DIG_BITS restoring steps; quotient bits shift in at the bottom of dvd
  always_comb begin
    dv = dvd_r;
    rm = rem_r;
    r8 = '0;
    for (int j = 0; j < DIG_BITS; j++) begin
      r8 = {rm, dv[DVD_W-1]};
      dv = {dv[DVD_W-2:0], 1'b0};
      if (r8 >= {1'b0, div_r}) begin
        rm    = TERMS_W'(r8 - {1'b0, div_r});
        dv[0] = 1'b1;
      end else begin
        rm = r8[TERMS_W-1:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    tol_nxt   = tol_r;
    x_mag_nxt = x_mag_r;
    x_pos_nxt = x_pos_r;
    term_nxt  = term_r;
    neg_nxt   = neg_r;
    sum_nxt   = sum_r;
    cnt_nxt   = cnt_r;
    div_nxt   = div_r;
    nc_nxt    = nc_r;
    mcnt_nxt  = mcnt_r;
    dcnt_nxt  = dcnt_r;
    prod_nxt  = prod_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    ov_nxt    = ov_r && out_stall;
    o_sum_nxt = o_sum_r;
    o_cnt_nxt = o_cnt_r;
    o_nc_nxt  = o_nc_r;
    upd_en    = 1'b0;
    upd_mag   = TERM_MAX;

    if (cfg_valid && cfg_ready) begin
      tol_nxt = cfg_stop_tolerance;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          x_pos_nxt = !in_x_value[X_W-1] && (in_x_value != '0);
          x_mag_nxt = in_x_value[X_W-1] ? MAG_W'(-in_x_value) : MAG_W'(in_x_value);
          term_nxt  = ONE_MAG;
          neg_nxt   = 1'b0;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          div_nxt   = TERMS_W'(2);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (run) begin
          if (sum_ext[ACC_W] != sum_ext[ACC_W-1]) begin
            sum_nxt = sum_ext[ACC_W] ? SUM_MIN : SUM_MAX;
          end else begin
            sum_nxt = sum_ext[ACC_W-1:0];
          end
          cnt_nxt   = cnt_r + 1'b1;
          prod_nxt  = '0;
          mcnt_nxt  = 2'(MUL_STEPS - 1);
          state_nxt = ST_MUL;
        end else begin
          nc_nxt    = tol_met;
          state_nxt = ST_FINISH;
        end
      end
      ST_MUL: begin
        // top slice first, accumulator shifts up one slice per step
        prod_nxt = (prod_r << CHUNK_W) + {{(PROD_W-PART_W){1'b0}}, mul_part};
        mcnt_nxt = mcnt_r - 1'b1;
        if (mcnt_r == '0) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (p_ovf) begin
          // quotient is beyond the term range for any divisor
          upd_en    = 1'b1;
          upd_mag   = TERM_MAX;
          state_nxt = ST_CHECK;
        end else begin
          dvd_nxt   = p_full[DVD_W-1:0];
          rem_nxt   = '0;
          dcnt_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        dvd_nxt  = dv;
        rem_nxt  = rm;
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(DIV_CYCLES - 1)) begin
          upd_en    = 1'b1;
          upd_mag   = (dv > DVD_W'(TERM_MAX)) ? TERM_MAX : dv[MAG_W-1:0];
          state_nxt = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          o_sum_nxt = sum_r[ACC_W-1] ? '0 : sum_r[SUM_W-1:0];
          o_cnt_nxt = cnt_r;
          o_nc_nxt  = nc_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (upd_en) begin
      term_nxt = upd_mag;
      neg_nxt  = (neg_r != x_pos_r) && (upd_mag != '0);
      div_nxt  = div_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tol_r   <= TOL_W'(1);
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tol_r   <= tol_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_mag_r <= x_mag_nxt;
    x_pos_r <= x_pos_nxt;
    term_r  <= term_nxt;
    neg_r   <= neg_nxt;
    sum_r   <= sum_nxt;
    cnt_r   <= cnt_nxt;
    div_r   <= div_nxt;
    nc_r    <= nc_nxt;
    mcnt_r  <= mcnt_nxt;
    dcnt_r  <= dcnt_nxt;
    prod_r  <= prod_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    o_sum_r <= o_sum_nxt;
    o_cnt_r <= o_cnt_nxt;
    o_nc_r  <= o_nc_nxt;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = ov_r;
  assign out_sum_value     = o_sum_r;
  assign out_terms_used    = o_cnt_r;
  assign out_not_converged = o_nc_r;

`ifndef SYNTHESIS
  // a new result word only ever comes out of the final sequencer state
  a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FINISH))
    else $error("result word loaded outside the final state");

  // non-convergence only when the term budget is used up
  a_nc_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_not_converged) |-> (out_terms_used == MAX_CNT))
    else $error("not_converged without reaching the term limit");

  a_terms_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_terms_used <= MAX_CNT))
    else $error("term count beyond the limit");

  // division remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("divider remainder not below divisor");
`endif

endmodule
